>>> rtl/bst_pkg.sv
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, constants and byte classes of the byte stream tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bst_pkg;

  localparam int LENGTH_WIDTH    = 16;
  localparam int POSITION_WIDTH  = 32;
  localparam int LINE_WIDTH      = 32;
  localparam int BYTE_WIDTH      = 8;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int MAX_LEN_WIDTH   = 16;
  localparam int CMP_WIDTH       = (LENGTH_WIDTH >= MAX_LEN_WIDTH) ? LENGTH_WIDTH + 1
                                                                    : MAX_LEN_WIDTH + 1;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);

  localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = MAX_LEN_WIDTH'(4096);

  localparam logic [BYTE_WIDTH-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_WIDTH-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_WIDTH-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_WIDTH-1:0] CH_UNDER = 8'h5F;

  typedef enum logic [2:0] {
    KIND_BYTE       = 3'd0,
    KIND_END        = 3'd1,
    KIND_SYMBOL     = 3'd2,
    KIND_NEWLINE    = 3'd3,
    KIND_LEN_ERROR  = 3'd4,
    KIND_STREAM_END = 3'd5
  } kind_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_REPORT_NL   = 2'd0,
    CFG_MINUS_ALPHA = 2'd1,
    CFG_MAX_LEN     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     report_nl;
    logic                     minus_alpha;
    logic [MAX_LEN_WIDTH-1:0] max_len;
  } cfg_t;

  typedef struct packed {
    kind_t                     kind;
    logic [BYTE_WIDTH-1:0]     byte_val;
    logic [LENGTH_WIDTH-1:0]   len;
    logic [POSITION_WIDTH-1:0] tstart;
  } result_t;

  // One accepted item: up to two results, a before b, sharing line fields.
  typedef struct packed {
    logic                      a_vld;
    result_t                   a;
    logic                      b_vld;
    result_t                   b;
    logic [LINE_WIDTH-1:0]     line;
    logic [POSITION_WIDTH-1:0] lstart;
  } entry_t;

  function automatic logic is_space(input logic [BYTE_WIDTH-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_CR) ||
           (c == CH_NL);
  endfunction

  function automatic logic is_word(input logic [BYTE_WIDTH-1:0] c, input logic minus_alpha);
    return (c inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER}) ||
           (minus_alpha && (c == CH_MINUS));
  endfunction

endpackage

`default_nettype wire

>>> rtl/bst_ifs.sv
// ----------------------------------------------------------------------------
// bst_in_if / bst_out_if
// Valid/ready channels of the tokenizer: raw bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bst_in_if;
  logic                             valid;
  logic                             ready;
  logic [bst_pkg::BYTE_WIDTH-1:0]   byte_in;
  logic                             end_of_stream;

  modport source (output valid, output byte_in, output end_of_stream, input ready);
  modport sink   (input valid, input byte_in, input end_of_stream, output ready);
endinterface

interface bst_out_if;
  logic                                 valid;
  logic                                 ready;
  bst_pkg::kind_t                       kind;
  logic [bst_pkg::BYTE_WIDTH-1:0]       byte_out;
  logic [bst_pkg::LENGTH_WIDTH-1:0]     token_length;
  logic [bst_pkg::LINE_WIDTH-1:0]       line_number;
  logic [bst_pkg::POSITION_WIDTH-1:0]   token_start;
  logic [bst_pkg::POSITION_WIDTH-1:0]   line_start;
  logic                                 last;

  modport source (output valid, output kind, output byte_out, output token_length,
                  output line_number, output token_start, output line_start,
                  output last, input ready);
  modport sink   (input valid, input kind, input byte_out, input token_length,
                  input line_number, input token_start, input line_start,
                  input last, output ready);
endinterface

`default_nettype wire

>>> rtl/bst_front.sv
// ----------------------------------------------------------------------------
// bst_front
// Classifies each byte, updates token and position state and queues the
// results the byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_front (
  input  logic                clk,
  input  logic                rst_n,
  bst_in_if.sink              in_item,
  input  bst_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output bst_pkg::entry_t     q_entry
);

  logic                                 in_token_r, in_token_nxt;
  logic                                 nl_pend_r, nl_pend_nxt;
  logic                                 discard_r, discard_nxt;
  logic [bst_pkg::LENGTH_WIDTH-1:0]     cur_len_r, cur_len_nxt;
  logic [bst_pkg::LINE_WIDTH-1:0]       line_cnt_r, line_cnt_nxt;
  logic [bst_pkg::POSITION_WIDTH-1:0]   byte_pos_r, byte_pos_nxt;
  logic [bst_pkg::POSITION_WIDTH-1:0]   line_begin_r, line_begin_nxt;
  logic [bst_pkg::POSITION_WIDTH-1:0]   start_off_r, start_off_nxt;

  logic                                 accept;
  logic [bst_pkg::BYTE_WIDTH-1:0]       c;
  logic                                 nl_flush;
  logic                                 new_tok;
  logic [bst_pkg::LENGTH_WIDTH-1:0]     len0;
  logic [bst_pkg::POSITION_WIDTH-1:0]   so;
  logic [bst_pkg::CMP_WIDTH-1:0]        grown_w;
  logic                                 overflow;
  bst_pkg::result_t                     nl_res;
  bst_pkg::result_t                     end_res;
  bst_pkg::entry_t                      ent;

  assign in_item.ready = !q_full;
  assign accept        = in_item.valid && !q_full;
  assign c             = in_item.byte_in;
  assign nl_flush      = nl_pend_r && cfg.report_nl;
  assign new_tok       = !in_token_r;
  assign len0          = new_tok ? '0 : cur_len_r;
  assign so            = new_tok ? byte_pos_r : start_off_r;
  assign grown_w       = bst_pkg::CMP_WIDTH'(len0) + bst_pkg::CMP_WIDTH'(1);
  assign overflow      = (grown_w > bst_pkg::CMP_WIDTH'(cfg.max_len)) ||
                         grown_w[bst_pkg::LENGTH_WIDTH];

  always_comb begin
    nl_res          = '0;
    nl_res.kind     = bst_pkg::KIND_NEWLINE;
    nl_res.tstart   = byte_pos_r;
    end_res         = '0;
    end_res.kind    = bst_pkg::KIND_END;
    end_res.len     = cur_len_r;
    end_res.tstart  = start_off_r;
  end

  always_comb begin
    in_token_nxt   = in_token_r;
    nl_pend_nxt    = nl_pend_r;
    discard_nxt    = discard_r;
    cur_len_nxt    = cur_len_r;
    line_cnt_nxt   = line_cnt_r;
    line_begin_nxt = line_begin_r;
    start_off_nxt  = start_off_r;
    byte_pos_nxt   = byte_pos_r + 1'b1;
    ent            = '0;
    ent.line       = line_cnt_r;
    ent.lstart     = line_begin_r;

    if (in_item.end_of_stream) begin
      if (in_token_r) begin
        ent.a_vld = 1'b1;
        ent.a     = end_res;
      end else if (nl_flush) begin
        ent.a_vld = 1'b1;
        ent.a     = nl_res;
      end
      ent.b_vld       = 1'b1;
      ent.b.kind      = bst_pkg::KIND_STREAM_END;
      ent.b.tstart    = byte_pos_r;
      in_token_nxt    = 1'b0;
      nl_pend_nxt     = 1'b0;
      discard_nxt     = 1'b0;
      cur_len_nxt     = '0;
      line_cnt_nxt    = '0;
      byte_pos_nxt    = '0;
      line_begin_nxt  = '0;
      start_off_nxt   = '0;
    end else if (bst_pkg::is_word(c, cfg.minus_alpha)) begin
      if (!discard_r) begin
        if (new_tok) begin
          ent.a_vld   = nl_flush;
          ent.a       = nl_res;
          nl_pend_nxt = 1'b0;
        end
        start_off_nxt = so;
        ent.b_vld     = 1'b1;
        ent.b.tstart  = so;
        if (overflow) begin
          ent.b.kind   = bst_pkg::KIND_LEN_ERROR;
          ent.b.len    = len0;
          in_token_nxt = 1'b0;
          discard_nxt  = 1'b1;
          cur_len_nxt  = '0;
        end else begin
          ent.b.kind     = bst_pkg::KIND_BYTE;
          ent.b.byte_val = c;
          ent.b.len      = grown_w[bst_pkg::LENGTH_WIDTH-1:0];
          in_token_nxt   = 1'b1;
          cur_len_nxt    = grown_w[bst_pkg::LENGTH_WIDTH-1:0];
        end
      end
    end else if (bst_pkg::is_space(c)) begin
      ent.a_vld    = in_token_r;
      ent.a        = end_res;
      in_token_nxt = 1'b0;
      discard_nxt  = 1'b0;
      cur_len_nxt  = '0;
      if (c == bst_pkg::CH_NL) begin
        line_cnt_nxt   = line_cnt_r + 1'b1;
        line_begin_nxt = byte_pos_r + 1'b1;
        nl_pend_nxt    = 1'b1;
      end
    end else begin
      if (in_token_r) begin
        ent.a_vld = 1'b1;
        ent.a     = end_res;
      end else if (nl_flush) begin
        ent.a_vld = 1'b1;
        ent.a     = nl_res;
      end
      nl_pend_nxt    = 1'b0;
      in_token_nxt   = 1'b0;
      discard_nxt    = 1'b0;
      cur_len_nxt    = '0;
      start_off_nxt  = byte_pos_r;
      ent.b_vld      = 1'b1;
      ent.b.kind     = bst_pkg::KIND_SYMBOL;
      ent.b.byte_val = c;
      ent.b.len      = bst_pkg::LENGTH_WIDTH'(1);
      ent.b.tstart   = byte_pos_r;
    end
  end

  assign q_push  = accept && (ent.a_vld || ent.b_vld);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_token_r   <= 1'b0;
      nl_pend_r    <= 1'b0;
      discard_r    <= 1'b0;
      cur_len_r    <= '0;
      line_cnt_r   <= '0;
      byte_pos_r   <= '0;
      line_begin_r <= '0;
      start_off_r  <= '0;
    end else if (accept) begin
      in_token_r   <= in_token_nxt;
      nl_pend_r    <= nl_pend_nxt;
      discard_r    <= discard_nxt;
      cur_len_r    <= cur_len_nxt;
      line_cnt_r   <= line_cnt_nxt;
      byte_pos_r   <= byte_pos_nxt;
      line_begin_r <= line_begin_nxt;
      start_off_r  <= start_off_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bst_fifo.sv
// ----------------------------------------------------------------------------
// bst_fifo
// Short queue of result entries between the classifier and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bst_pkg::entry_t   push_entry,
  input  logic              pop,
  output bst_pkg::entry_t   head,
  output logic              full,
  output logic              empty
);

  bst_pkg::entry_t                       mem_r [bst_pkg::FIFO_DEPTH];
  logic [bst_pkg::FIFO_PTR_WIDTH-1:0]    wr_ptr_r;
  logic [bst_pkg::FIFO_PTR_WIDTH-1:0]    rd_ptr_r;
  logic [bst_pkg::FIFO_PTR_WIDTH:0]      cnt_r, cnt_nxt;

  assign full  = (cnt_r == (bst_pkg::FIFO_PTR_WIDTH + 1)'(bst_pkg::FIFO_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bst_back.sv
// ----------------------------------------------------------------------------
// bst_back
// Unpacks queued entries into single results and holds them in the output
// register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  bst_pkg::entry_t   head,
  input  logic              q_empty,
  output logic              q_pop,
  bst_out_if.source         out_item
);

  logic                                phase_r;
  logic                                out_vld_r;
  bst_pkg::result_t                    res_r;
  logic [bst_pkg::LINE_WIDTH-1:0]      line_r;
  logic [bst_pkg::POSITION_WIDTH-1:0]  lstart_r;
  logic                                last_r;

  logic                                sel_b;
  logic                                done;
  logic                                load;
  bst_pkg::result_t                    res;

  assign sel_b = phase_r || !head.a_vld;
  assign res   = sel_b ? head.b : head.a;
  assign done  = sel_b || !head.b_vld;
  assign load  = !q_empty && (!out_vld_r || out_item.ready);
  assign q_pop = load && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        phase_r   <= !done;
        out_vld_r <= 1'b1;
      end else if (out_item.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r    <= res;
      line_r   <= head.line;
      lstart_r <= head.lstart;
      last_r   <= done;
    end
  end

  assign out_item.valid        = out_vld_r;
  assign out_item.kind         = res_r.kind;
  assign out_item.byte_out     = res_r.byte_val;
  assign out_item.token_length = res_r.len;
  assign out_item.line_number  = line_r;
  assign out_item.token_start  = res_r.tstart;
  assign out_item.line_start   = lstart_r;
  assign out_item.last         = last_r;

endmodule

`default_nettype wire

>>> rtl/byte_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// byte_stream_tokenizer
// Splits a byte stream into word, symbol and newline tokens with positions.
// ----------------------------------------------------------------------------
// A byte is accepted every cycle while the four-entry result queue has room;
// the classifier updates all counters in that same cycle. Each byte yields
// zero, one or two results, and the output register delivers one result per
// cycle while the receiver is ready; a byte with two results (token end or
// newline before a symbol or stream end, or newline before a word byte)
// sends them one after the other. Results pass the result queue and then
// the output register. Configuration writes take effect at the next edge.
`default_nettype none

module byte_stream_tokenizer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  bst_in_if.sink                                 in_item,
  bst_out_if.source                              out_item,
  input  logic                                   cfg_we,
  input  logic [bst_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [bst_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

  bst_pkg::cfg_t    cfg_r;
  logic             q_full;
  logic             q_empty;
  logic             q_push;
  logic             q_pop;
  bst_pkg::entry_t  q_entry;
  bst_pkg::entry_t  q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.report_nl   <= 1'b0;
      cfg_r.minus_alpha <= 1'b0;
      cfg_r.max_len     <= bst_pkg::MAX_LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bst_pkg::CFG_REPORT_NL:   cfg_r.report_nl   <= cfg_data[0];
        bst_pkg::CFG_MINUS_ALPHA: cfg_r.minus_alpha <= cfg_data[0];
        bst_pkg::CFG_MAX_LEN:     cfg_r.max_len     <= cfg_data[bst_pkg::MAX_LEN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  bst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  bst_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  bst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_item (out_item)
  );

  a_stream_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.kind == bst_pkg::KIND_STREAM_END)) |-> out_item.last)
    else $error("stream end item not marked last");

  a_byte_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.kind == bst_pkg::KIND_BYTE)) |-> (out_item.token_length != '0))
    else $error("token byte with zero length");

  a_symbol_len_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.kind == bst_pkg::KIND_SYMBOL)) |->
      (out_item.token_length == bst_pkg::LENGTH_WIDTH'(1)))
    else $error("symbol token length not one");

  a_newline_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_item.valid && (out_item.kind == bst_pkg::KIND_NEWLINE)) |-> cfg_r.report_nl)
    else $error("newline token while reporting is off");

endmodule

`default_nettype wire
